[rtl/assert_macros.svh]
// Assertion macros for the checker file olpr_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that disables it.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that is checked during reset too.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[rtl/olpr_pkg.sv]
// Types and constants for the octree level parent reducer.
// No dependencies.
package olpr_pkg;

   localparam int PARENT_W   = 27;
   localparam int OCT_N      = 8;
   localparam int OCT_BITS   = 3;
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = 2;
   localparam int RSP_CNT_W  = 3;

   localparam logic [OCT_N-1:0] MASK_FULL = '1;

   typedef struct packed {
      logic [PARENT_W-1:0] parent_code;
      logic                parent_solid;
      logic [OCT_N-1:0]    octant_mask;
      logic                last_parent;
      logic                converged;
   } rsp_item_type;

endpackage

[rtl/octree_level_parent_reducer_top.sv]
// Octree level parent reducer: groups sorted child codes by parent and emits parent nodes.
// Depends on olpr_pkg.
//
// Takes one child transaction per cycle. A child whose parent differs from the open
// group flushes that group as a result; a child with level_end set flushes its own
// group with last_parent high and clears all group state. So one transaction yields
// zero, one or two results. Results go through a four-entry queue; req_ready stays
// high while that queue holds two results or fewer, so with rsp_ready held high the
// block takes a transaction every cycle. Results are registered into the queue, and the
// rsp_ ports show the oldest result that the queue holds.
module octree_level_parent_reducer_top #(
   parameter int CODE_BITS = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [CODE_BITS-1:0]              req_node_code,
   input  logic                              req_node_solid,
   input  logic                              req_level_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [olpr_pkg::PARENT_W-1:0]     rsp_parent_code,
   output logic                              rsp_parent_solid,
   output logic [olpr_pkg::OCT_N-1:0]        rsp_octant_mask,
   output logic                              rsp_last_parent,
   output logic                              rsp_converged
);
   import olpr_pkg::*;

   localparam int PW    = (CODE_BITS > OCT_BITS) ? CODE_BITS - OCT_BITS : 1;
   localparam int EXT_W = (PW > PARENT_W) ? PW : PARENT_W;

   logic [PW-1:0]        group_parent_ff, group_parent_in;
   logic [OCT_N-1:0]     group_mask_ff, group_mask_in;
   logic                 group_all_solid_ff, group_all_solid_in;
   logic                 group_open_ff, group_open_in;
   logic                 emitted_any_ff, emitted_any_in;

   rsp_item_type         fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   logic                 accept, pop;
   logic [PW-1:0]        parent;
   logic [OCT_BITS-1:0]  oct;
   logic                 change, fresh;
   logic [OCT_N-1:0]     base_mask, mask_n;
   logic                 solid_n, old_full, new_full, emitted_n;
   logic                 push_a, push_b;
   logic [EXT_W-1:0]     old_ext, new_ext;
   rsp_item_type         res_a, res_b, slot0, slot1;
   logic [RSP_CNT_W-1:0] n_push;

   assign req_ready = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   assign parent = PW'(req_node_code >> OCT_BITS);
   assign oct    = req_node_code[OCT_BITS-1:0];
   assign change = group_open_ff && (parent != group_parent_ff);
   assign fresh  = change || !group_open_ff;

   assign base_mask = fresh ? '0 : group_mask_ff;
   assign mask_n    = base_mask | (OCT_N'(1) << oct);
   assign solid_n   = (fresh || group_all_solid_ff) && req_node_solid;
   assign old_full  = group_all_solid_ff && (group_mask_ff == MASK_FULL);
   assign new_full  = solid_n && (mask_n == MASK_FULL);
   assign emitted_n = emitted_any_ff || change;

   assign old_ext = EXT_W'(group_parent_ff);
   assign new_ext = EXT_W'(parent);

   always_comb begin
      res_a.parent_code  = old_ext[PARENT_W-1:0];
      res_a.parent_solid = old_full;
      res_a.octant_mask  = old_full ? '0 : group_mask_ff;
      res_a.last_parent  = 1'b0;
      res_a.converged    = 1'b0;
      res_b.parent_code  = new_ext[PARENT_W-1:0];
      res_b.parent_solid = new_full;
      res_b.octant_mask  = new_full ? '0 : mask_n;
      res_b.last_parent  = 1'b1;
      res_b.converged    = !emitted_n && (parent == '0);
   end

   assign push_a = accept && change;
   assign push_b = accept && req_level_end;
   assign slot0  = push_a ? res_a : res_b;
   assign slot1  = res_b;
   assign n_push = RSP_CNT_W'(push_a) + RSP_CNT_W'(push_b);

   always_comb begin
      group_parent_in    = group_parent_ff;
      group_mask_in      = group_mask_ff;
      group_all_solid_in = group_all_solid_ff;
      group_open_in      = group_open_ff;
      emitted_any_in     = emitted_any_ff;
      if (accept) begin
         if (req_level_end) begin
            group_parent_in    = '0;
            group_mask_in      = '0;
            group_all_solid_in = 1'b1;
            group_open_in      = 1'b0;
            emitted_any_in     = 1'b0;
         end else begin
            group_parent_in    = parent;
            group_mask_in      = mask_n;
            group_all_solid_in = solid_n;
            group_open_in      = 1'b1;
            emitted_any_in     = emitted_n;
         end
      end
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + n_push - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_parent_ff    <= '0;
         group_mask_ff      <= '0;
         group_all_solid_ff <= 1'b1;
         group_open_ff      <= 1'b0;
         emitted_any_ff     <= 1'b0;
         wr_ptr_ff          <= '0;
         rd_ptr_ff          <= '0;
         count_ff           <= '0;
      end else begin
         group_parent_ff    <= group_parent_in;
         group_mask_ff      <= group_mask_in;
         group_all_solid_ff <= group_all_solid_in;
         group_open_ff      <= group_open_in;
         emitted_any_ff     <= emitted_any_in;
         wr_ptr_ff          <= wr_ptr_in;
         rd_ptr_ff          <= rd_ptr_in;
         count_ff           <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a || push_b) begin
         fifo_ff[wr_ptr_ff] <= slot0;
      end
      if (push_a && push_b) begin
         fifo_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= slot1;
      end
   end

   assign rsp_parent_code  = fifo_ff[rd_ptr_ff].parent_code;
   assign rsp_parent_solid = fifo_ff[rd_ptr_ff].parent_solid;
   assign rsp_octant_mask  = fifo_ff[rd_ptr_ff].octant_mask;
   assign rsp_last_parent  = fifo_ff[rd_ptr_ff].last_parent;
   assign rsp_converged    = fifo_ff[rd_ptr_ff].converged;

endmodule

[rtl/olpr_checker.sv]
// Port-level checks on the octree level parent reducer's result channel, and its bind.
// Depends on olpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module olpr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [olpr_pkg::PARENT_W-1:0] rsp_parent_code,
   input logic                          rsp_parent_solid,
   input logic [olpr_pkg::OCT_N-1:0]    rsp_octant_mask,
   input logic                          rsp_last_parent,
   input logic                          rsp_converged
);
   import olpr_pkg::*;

   `ASSERT_CLK(a_idle_after_reset, clock, reset |=> !rsp_valid)
   `ASSERT_CLK_RST(a_valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK_RST(a_conv_on_last, clock, reset,
      rsp_valid && rsp_converged |-> rsp_last_parent && (rsp_parent_code == '0))
   `ASSERT_CLK_RST(a_solid_empty_mask, clock, reset,
      rsp_valid && rsp_parent_solid |-> (rsp_octant_mask == '0))
   `ASSERT_CLK_RST(a_mixed_has_child, clock, reset,
      rsp_valid && !rsp_parent_solid |-> (rsp_octant_mask != '0))

endmodule

bind octree_level_parent_reducer_top olpr_checker u_olpr_checker (.*);
